// ----- hdl/lrso_pkg.sv -----
// Shared types, constants and helper functions for the list range slice offsets block.
`default_nettype none

package lrso_pkg;

    localparam int IDX_W = 64;
    localparam int REG_W = 64;
    localparam int POS_W = 63;
    localparam int CFG_IDX_W = 2;

    localparam int DIV_N_W = POS_W;
    localparam int DIV_D_W = REG_W;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd2;

    localparam logic [REG_W-1:0] NONE_RAW = 64'd1 << (IDX_W - 1);
    localparam logic [REG_W-1:0] NONE_BITS = ~((64'd1 << (IDX_W - 1)) - 64'd1);
    localparam logic [REG_W-1:0] STEP_RESET = 64'd1;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef struct packed {
        logic [POS_W-1:0] list_begin;
        logic [POS_W-1:0] list_end;
        logic             restart;
    } in_t;

    typedef struct packed {
        logic [POS_W-1:0] first_index;
        logic [POS_W-1:0] selected_count;
        logic [POS_W-1:0] running_offset;
        logic             error_flag;
    } out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [REG_W-1:0] sext_idx(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] r;
        for (int i = 0; i < REG_W; i++)
        begin
            r[i] = (i < IDX_W) ? v[i] : v[IDX_W-1];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/list_range_slice_offsets_top.sv -----
// Top level of the list range slice offsets block: sequencer, slice clamping and offset.
// Each transaction on the input channel is one list [list_begin, list_end). The block
// applies the configured start:stop:step slice to it, with the minimum signed value of
// start or stop meaning unspecified, and returns one transaction holding the first selected
// absolute index, the selected count, the saturating running offset and an error flag.
// An error list goes straight to the output stage, a list that selects nothing skips the
// divider, and any other list passes through the bit-serial divider that forms the ceiling
// division by the step magnitude. Input stall is high while a list is being worked on,
// and a finished list also waits while the output register still holds a stalled result.
// A finished result waits in the output register while the next list is already taken.
// Configuration is written through the plain write port and must be changed only when idle.
`default_nettype none

module list_range_slice_offsets_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire lrso_pkg::in_t                    in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output lrso_pkg::out_t                        out_data,
    input  wire logic                             cfg_we,
    input  wire logic [lrso_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lrso_pkg::REG_W-1:0]       cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_ADJ,
        S_CLAMP,
        S_DIFF,
        S_DIV,
        S_FIN
    } state_t;

    state_t                              state_reg;
    logic [lrso_pkg::REG_W-1:0]          start_cfg_reg;
    logic [lrso_pkg::REG_W-1:0]          stop_cfg_reg;
    logic [lrso_pkg::REG_W-1:0]          step_cfg_reg;
    lrso_pkg::in_t                       item_reg;
    logic [lrso_pkg::POS_W-1:0]          offset_reg;
    logic                                fwd_reg;
    logic                                err_reg;
    logic signed [lrso_pkg::REG_W-1:0]   len_reg;
    logic signed [lrso_pkg::REG_W-1:0]   len_m1_reg;
    logic [lrso_pkg::REG_W-1:0]          mag_reg;
    logic signed [lrso_pkg::REG_W-1:0]   rs_reg;
    logic signed [lrso_pkg::REG_W-1:0]   re_reg;
    logic [lrso_pkg::DIV_N_W-1:0]        dm1_reg;
    logic [lrso_pkg::POS_W-1:0]          count_reg;
    logic                                div_start_reg;
    logic                                out_valid_reg;
    lrso_pkg::out_t                      out_reg;

    logic [lrso_pkg::REG_W-1:0]          start_s;
    logic [lrso_pkg::REG_W-1:0]          stop_s;
    logic [lrso_pkg::REG_W-1:0]          step_s;
    logic                                start_none;
    logic                                stop_none;
    logic signed [lrso_pkg::REG_W-1:0]   start_adj;
    logic signed [lrso_pkg::REG_W-1:0]   stop_adj;
    logic signed [lrso_pkg::REG_W-1:0]   lo;
    logic signed [lrso_pkg::REG_W-1:0]   hi;
    logic signed [lrso_pkg::REG_W-1:0]   rs_next;
    logic signed [lrso_pkg::REG_W-1:0]   re_next;
    logic [lrso_pkg::REG_W-1:0]          diff_a;
    logic [lrso_pkg::REG_W-1:0]          diff_b;
    logic [lrso_pkg::REG_W:0]            dm1_next;
    logic [lrso_pkg::REG_W-1:0]          offset_sum;
    logic [lrso_pkg::POS_W-1:0]          first_next;
    lrso_pkg::div_status_t               div_status;
    logic [lrso_pkg::DIV_N_W-1:0]        quotient;
    logic                                in_accept;
    logic                                out_free;

    assign start_s = lrso_pkg::sext_idx(start_cfg_reg);
    assign stop_s = lrso_pkg::sext_idx(stop_cfg_reg);
    assign step_s = lrso_pkg::sext_idx(step_cfg_reg);
    assign start_none = (start_s == lrso_pkg::NONE_BITS);
    assign stop_none = (stop_s == lrso_pkg::NONE_BITS);

    always_comb
    begin
        if (start_none)
        begin
            start_adj = fwd_reg ? '0 : len_m1_reg;
        end
        else if (start_s[lrso_pkg::REG_W-1])
        begin
            start_adj = $signed(start_s) + len_reg;
        end
        else
        begin
            start_adj = $signed(start_s);
        end

        if (stop_none)
        begin
            stop_adj = fwd_reg ? len_reg : '1;
        end
        else if (stop_s[lrso_pkg::REG_W-1])
        begin
            stop_adj = $signed(stop_s) + len_reg;
        end
        else
        begin
            stop_adj = $signed(stop_s);
        end
    end

    assign lo = fwd_reg ? '0 : '1;
    assign hi = fwd_reg ? len_reg : len_m1_reg;

    always_comb
    begin
        rs_next = rs_reg;
        if (rs_reg < lo)
        begin
            rs_next = lo;
        end
        else if (rs_reg > hi)
        begin
            rs_next = hi;
        end

        re_next = re_reg;
        if (re_reg < lo)
        begin
            re_next = lo;
        end
        else if (re_reg > hi)
        begin
            re_next = hi;
        end
    end

    assign diff_a = fwd_reg ? re_reg : rs_reg;
    assign diff_b = fwd_reg ? rs_reg : re_reg;
    assign dm1_next = {diff_a[lrso_pkg::REG_W-1], diff_a} + ~{diff_b[lrso_pkg::REG_W-1], diff_b};

    assign offset_sum = {1'b0, offset_reg} + {1'b0, count_reg};
    assign first_next = item_reg.list_begin + rs_reg[lrso_pkg::POS_W-1:0];

    assign in_accept = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    lrso_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dm1_reg),
        .divisor  (mag_reg),
        .status   (div_status),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_cfg_reg <= lrso_pkg::NONE_RAW;
            stop_cfg_reg <= lrso_pkg::NONE_RAW;
            step_cfg_reg <= lrso_pkg::STEP_RESET;
            offset_reg <= '0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= (state_reg == S_DIFF) && !dm1_next[lrso_pkg::REG_W];
            if (out_valid_reg && !out_stall && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    lrso_pkg::CFG_START: start_cfg_reg <= cfg_data;
                    lrso_pkg::CFG_STOP:  stop_cfg_reg <= cfg_data;
                    lrso_pkg::CFG_STEP:  step_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        item_reg <= in_data;
                        state_reg <= S_LEN;
                    end
                end
                S_LEN:
                begin
                    if (item_reg.restart)
                    begin
                        offset_reg <= '0;
                    end
                    fwd_reg <= !step_s[lrso_pkg::REG_W-1];
                    mag_reg <= step_s[lrso_pkg::REG_W-1] ? ('0 - step_s) : step_s;
                    len_reg <= {1'b0, item_reg.list_end - item_reg.list_begin};
                    len_m1_reg <= {1'b0, item_reg.list_end - item_reg.list_begin} - 64'sd1;
                    count_reg <= '0;
                    if ((step_s == '0) || (item_reg.list_end < item_reg.list_begin))
                    begin
                        err_reg <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        err_reg <= 1'b0;
                        state_reg <= S_ADJ;
                    end
                end
                S_ADJ:
                begin
                    rs_reg <= start_adj;
                    re_reg <= stop_adj;
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    rs_reg <= rs_next;
                    re_reg <= re_next;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    dm1_reg <= dm1_next[lrso_pkg::DIV_N_W-1:0];
                    if (!dm1_next[lrso_pkg::REG_W])
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_DIV:
                begin
                    if (div_status.done)
                    begin
                        count_reg <= quotient + 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        if (offset_sum[lrso_pkg::REG_W-1])
                        begin
                            offset_reg <= lrso_pkg::POS_MAX;
                            out_reg.running_offset <= lrso_pkg::POS_MAX;
                        end
                        else
                        begin
                            offset_reg <= offset_sum[lrso_pkg::POS_W-1:0];
                            out_reg.running_offset <= offset_sum[lrso_pkg::POS_W-1:0];
                        end
                        out_reg.selected_count <= count_reg;
                        out_reg.first_index <= (count_reg != '0) ? first_next : '0;
                        out_reg.error_flag <= err_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.error_flag
            || (out_data.selected_count == '0 && out_data.first_index == '0)))
        else $error("An error transaction carries a nonzero count or index.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.selected_count == '0) |-> (out_data.first_index == '0))
        else $error("An empty selection reports a nonzero first index.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.running_offset >= out_data.selected_count))
        else $error("Running offset is below the count of its own list.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (div_status.busy || div_start_reg) |-> (state_reg == S_DIV))
        else $error("Divider is active outside the divide state.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> (out_valid && state_reg == S_IDLE))
        else $error("A finished list did not reach the output register.");
`endif

endmodule

`default_nettype wire

// ----- hdl/lrso_div.sv -----
// Radix-2 restoring divider that produces one quotient bit per cycle.
`default_nettype none

module lrso_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lrso_pkg::DIV_N_W-1:0]  dividend,
    input  wire logic [lrso_pkg::DIV_D_W-1:0]  divisor,
    output lrso_pkg::div_status_t              status,
    output logic      [lrso_pkg::DIV_N_W-1:0]  quotient
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [lrso_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [lrso_pkg::DIV_N_W-1:0]     quo_reg;
    logic [lrso_pkg::DIV_D_W-2:0]     rem_reg;
    logic [lrso_pkg::DIV_D_W-1:0]     shifted;
    logic                             ge;
    logic [lrso_pkg::DIV_D_W-1:0]     rem_next;
    logic                             last_step;

    assign shifted = {rem_reg, quo_reg[lrso_pkg::DIV_N_W-1]};
    assign ge = (shifted >= divisor);
    assign rem_next = ge ? (shifted - divisor) : shifted;
    assign last_step = (cnt_reg == lrso_pkg::DIV_CNT_W'(lrso_pkg::DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
                quo_reg <= dividend;
                rem_reg <= '0;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[lrso_pkg::DIV_N_W-2:0], ge};
                rem_reg <= rem_next[lrso_pkg::DIV_D_W-2:0];
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for list_range_slice_offsets_top: predicts every result and compares.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES = 11;
    localparam int LISTS_PER_PHASE = 105;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [lrso_pkg::REG_W-1:0] IDX_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [lrso_pkg::REG_W-1:0] IDX_MIN_PLUS1 = 64'h8000_0000_0000_0001;
    localparam logic [lrso_pkg::REG_W-1:0] MINUS_ONE = 64'hffff_ffff_ffff_ffff;

    typedef enum int {RX_OPEN, RX_COIN, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    class slice_scoreboard;
        logic [lrso_pkg::REG_W-1:0] start_reg;
        logic [lrso_pkg::REG_W-1:0] stop_reg;
        logic [lrso_pkg::REG_W-1:0] step_reg;
        logic [lrso_pkg::POS_W-1:0] offset_total;
        lrso_pkg::out_t slices_due[$];
        int failures;

        function new();
            start_reg = lrso_pkg::NONE_RAW;
            stop_reg = lrso_pkg::NONE_RAW;
            step_reg = lrso_pkg::STEP_RESET;
            offset_total = '0;
            failures = 0;
        endfunction

        function void write_reg(logic [lrso_pkg::CFG_IDX_W-1:0] idx,
                                logic [lrso_pkg::REG_W-1:0] value);
            case (idx)
                lrso_pkg::CFG_START: start_reg = value;
                lrso_pkg::CFG_STOP: stop_reg = value;
                lrso_pkg::CFG_STEP: step_reg = value;
                default: ;
            endcase
        endfunction

        function longint as_index(logic [lrso_pkg::REG_W-1:0] raw);
            logic [63:0] shifted;
            shifted = raw << (64 - lrso_pkg::IDX_W);
            return $signed(shifted) >>> (64 - lrso_pkg::IDX_W);
        endfunction

        function longint clamp_bound(longint v, bit unset, longint dflt, longint lo,
                                     longint hi, longint len);
            longint r;
            if (unset)
                r = dflt;
            else if (v < 0)
                r = v + len;
            else
                r = v;
            if (r < lo)
                r = lo;
            if (r > hi)
                r = hi;
            return r;
        endfunction

        function lrso_pkg::out_t predict_slice(lrso_pkg::in_t item);
            lrso_pkg::out_t res;
            longint none_val;
            longint start_v;
            longint stop_v;
            longint step;
            longint len;
            longint from_pos;
            longint to_pos;
            logic [63:0] mag;
            logic [63:0] diff;
            logic [63:0] count;
            bit is_err;
            res = '0;
            is_err = 1'b0;
            count = '0;
            diff = '0;
            none_val = as_index(lrso_pkg::NONE_RAW);
            start_v = as_index(start_reg);
            stop_v = as_index(stop_reg);
            step = as_index(step_reg);
            if (item.restart)
                offset_total = '0;
            if (step == 0 || item.list_end < item.list_begin)
            begin
                is_err = 1'b1;
            end
            else
            begin
                len = longint'({1'b0, item.list_end - item.list_begin});
                if (step > 0)
                begin
                    mag = step;
                    from_pos = clamp_bound(start_v, start_v == none_val, 0, 0, len, len);
                    to_pos = clamp_bound(stop_v, stop_v == none_val, len, 0, len, len);
                    if (to_pos > from_pos)
                        diff = to_pos - from_pos;
                end
                else
                begin
                    mag = 64'd0 - step;
                    from_pos = clamp_bound(start_v, start_v == none_val, len - 1, -1,
                                           len - 1, len);
                    to_pos = clamp_bound(stop_v, stop_v == none_val, -1, -1, len - 1, len);
                    if (from_pos > to_pos)
                        diff = from_pos - to_pos;
                end
                if (diff != 0)
                begin
                    count = (diff - 64'd1) / mag + 64'd1;
                    res.first_index = item.list_begin + from_pos[lrso_pkg::POS_W-1:0];
                end
            end
            if (count[lrso_pkg::POS_W-1:0] > lrso_pkg::POS_MAX - offset_total)
                offset_total = lrso_pkg::POS_MAX;
            else
                offset_total = offset_total + count[lrso_pkg::POS_W-1:0];
            res.selected_count = count[lrso_pkg::POS_W-1:0];
            res.running_offset = offset_total;
            res.error_flag = is_err;
            return res;
        endfunction

        function void note_list(lrso_pkg::in_t item);
            slices_due.push_back(predict_slice(item));
        endfunction

        function void check_slice(lrso_pkg::out_t got);
            lrso_pkg::out_t want;
            if (slices_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("tb_top: unexpected result first=%0d count=%0d offset=%0d err=%0b",
                             got.first_index, got.selected_count, got.running_offset,
                             got.error_flag);
                return;
            end
            want = slices_due.pop_front();
            if (got.first_index !== want.first_index
                || got.selected_count !== want.selected_count
                || got.running_offset !== want.running_offset
                || got.error_flag !== want.error_flag)
            begin
                failures++;
                if (failures <= 10)
                    $display({"tb_top: mismatch expected first=%0d count=%0d offset=%0d err=%0b",
                              " got first=%0d count=%0d offset=%0d err=%0b"},
                             want.first_index, want.selected_count, want.running_offset,
                             want.error_flag, got.first_index, got.selected_count,
                             got.running_offset, got.error_flag);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    lrso_pkg::in_t in_data = '0;
    logic out_stall = 1'b0;
    logic cfg_we = 1'b0;
    logic [lrso_pkg::CFG_IDX_W-1:0] cfg_index = lrso_pkg::CFG_START;
    logic [lrso_pkg::REG_W-1:0] cfg_data = '0;
    logic in_stall;
    logic out_valid;
    lrso_pkg::out_t out_data;

    slice_scoreboard sb;
    int burst_left = 0;
    int idle_cycles = 0;
    rx_mode_t stall_mode = RX_OPEN;
    int stall_left = 0;

    list_range_slice_offsets_top i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Results are checked before the input of the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_slice(out_data);
            if (in_valid && !in_stall)
                sb.note_list(in_data);
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 400);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            RX_OPEN: out_stall <= 1'b0;
            RX_COIN: out_stall <= 1'($urandom_range(0, 1));
            RX_HEAVY: out_stall <= ($urandom_range(0, 5) != 0);
            default: out_stall <= ((stall_left % 50) < 30);
        endcase
    end

    function automatic logic [lrso_pkg::REG_W-1:0] random_bound();
        case ($urandom_range(0, 7))
            0: return lrso_pkg::NONE_RAW;
            1: return 64'd0;
            2: return 64'($urandom_range(1, 40));
            3: return 64'd0 - 64'($urandom_range(1, 40));
            4: return IDX_MAX;
            5: return IDX_MIN_PLUS1;
            6: return 64'($urandom_range(41, 3000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [lrso_pkg::REG_W-1:0] random_step();
        case ($urandom_range(0, 11))
            0: return 64'd1;
            1: return MINUS_ONE;
            2: return 64'($urandom_range(2, 9));
            3: return 64'd0 - 64'($urandom_range(2, 9));
            4: return 64'($urandom_range(10, 1000));
            5: return 64'd0 - 64'($urandom_range(10, 1000));
            6: return IDX_MAX;
            7: return 64'd0 - IDX_MAX;
            8: return lrso_pkg::NONE_RAW;
            9: return 64'd0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic lrso_pkg::in_t random_list();
        lrso_pkg::in_t item;
        logic [lrso_pkg::POS_W-1:0] span;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            item.list_begin = 63'($urandom_range(0, 1000));
        else if (pick < 8)
            item.list_begin = 63'({$urandom, $urandom});
        else
            item.list_begin = lrso_pkg::POS_MAX - 63'($urandom_range(0, 1000));
        pick = $urandom_range(0, 99);
        if (pick >= 86 && pick < 94 && item.list_begin != 0)
        begin
            item.list_end = 63'({$urandom, $urandom}) % item.list_begin;
        end
        else
        begin
            if (pick < 65)
                span = 63'($urandom_range(0, 40));
            else if (pick < 78)
                span = 63'($urandom_range(41, 3000));
            else if (pick < 94)
                span = 63'({$urandom, $urandom});
            else
            begin
                item.list_begin = 63'($urandom_range(0, 3));
                span = lrso_pkg::POS_MAX;
            end
            if (span > lrso_pkg::POS_MAX - item.list_begin)
                span = lrso_pkg::POS_MAX - item.list_begin;
            item.list_end = item.list_begin + span;
        end
        item.restart = ($urandom_range(0, 7) == 0);
        return item;
    endfunction

    // One transaction per call; valid stays high inside a burst.
    task automatic send_list(lrso_pkg::in_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_data <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    task automatic set_slice(logic [lrso_pkg::REG_W-1:0] start_val,
                             logic [lrso_pkg::REG_W-1:0] stop_val,
                             logic [lrso_pkg::REG_W-1:0] step_val);
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.slices_due.size() != 0);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= lrso_pkg::CFG_START;
        cfg_data <= start_val;
        sb.write_reg(lrso_pkg::CFG_START, start_val);
        @(posedge clk);
        cfg_index <= lrso_pkg::CFG_STOP;
        cfg_data <= stop_val;
        sb.write_reg(lrso_pkg::CFG_STOP, stop_val);
        @(posedge clk);
        cfg_index <= lrso_pkg::CFG_STEP;
        cfg_data <= step_val;
        sb.write_reg(lrso_pkg::CFG_STEP, step_val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: whole list, unit step.
        send_list({63'd0, 63'd0, 1'b0});
        send_list({63'd0, 63'd10, 1'b0});
        send_list({63'd5, 63'd3, 1'b0});
        send_list({63'd0, lrso_pkg::POS_MAX, 1'b0});
        send_list({lrso_pkg::POS_MAX, lrso_pkg::POS_MAX, 1'b1});
        send_list({lrso_pkg::POS_MAX - 63'd1, lrso_pkg::POS_MAX, 1'b0});
        send_list({63'd100, 63'd200, 1'b1});

        set_slice(64'd0 - 64'd3, lrso_pkg::NONE_RAW, 64'd0 - 64'd2);
        send_list({63'd10, 63'd30, 1'b0});
        send_list({63'd0, 63'd5, 1'b0});
        send_list({63'd1000, 63'd1000, 1'b0});

        set_slice(64'd0, 64'd10, 64'd0);
        send_list({63'd0, 63'd50, 1'b0});
        send_list({63'd7, 63'd7, 1'b1});

        set_slice(lrso_pkg::NONE_RAW, lrso_pkg::NONE_RAW, lrso_pkg::NONE_RAW);
        send_list({63'd0, 63'd100, 1'b0});
        send_list({63'd0, lrso_pkg::POS_MAX, 1'b0});

        set_slice(IDX_MAX, IDX_MIN_PLUS1, IDX_MAX);
        send_list({63'd0, 63'd20, 1'b0});

        set_slice(64'd2, 64'd0 - 64'd2, 64'd3);
        send_list({63'd50, 63'd70, 1'b0});
        send_list({lrso_pkg::POS_MAX - 63'd30, lrso_pkg::POS_MAX, 1'b0});

        set_slice(IDX_MAX, IDX_MIN_PLUS1, 64'd0 - IDX_MAX);
        send_list({63'd0, 63'd40, 1'b0});
        send_list({63'd123, lrso_pkg::POS_MAX, 1'b1});

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                set_slice(lrso_pkg::NONE_RAW, lrso_pkg::NONE_RAW, 64'd1);
            else if (p == 1)
                set_slice(lrso_pkg::NONE_RAW, lrso_pkg::NONE_RAW, MINUS_ONE);
            else
                set_slice(random_bound(), random_bound(), random_step());
            repeat (LISTS_PER_PHASE) send_list(random_list());
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (sb.slices_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.slices_due.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
